>>> src/ctl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared types and constants for the configuration text lexer.
// ----------------------------------------------------------------------------
package ctl_pkg;

  // Default counter widths
  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 12;

  // Fixed payload widths
  localparam int TEXT_W     = 8;
  localparam int TOKEN_LINE_W = 16;
  localparam int TOKEN_COL_W  = 12;

  // Result queue depth (holds two items per input plus slack)
  localparam int RES_DEPTH = 4;

  // Event codes
  localparam logic EV_CONTENT = 1'b0;
  localparam logic EV_DONE    = 1'b1;

  // Token kinds
  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_DELIM  = 2'd2;
  localparam logic [1:0] KIND_STRING = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Lexer mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NAME   = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_STRING = 4'b1000
  } mode_t;

  // One result item
  typedef struct packed {
    logic                    event_kind;
    logic [1:0]              token_kind;
    logic [TEXT_W-1:0]       token_byte;
    logic [TOKEN_LINE_W-1:0] token_line;
    logic [TOKEN_COL_W-1:0]  start_column;
    logic [TOKEN_COL_W-1:0]  end_column;
    logic                    last_of_run;
  } result_t;

  // Up to two results pushed per processed byte; v1 implies v0
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

>>> src/ctl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_if
// Valid/ready channels for text bytes in and lexer results out.
// ----------------------------------------------------------------------------
interface ctl_in_if;
  import ctl_pkg::*;

  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface ctl_out_if;
  import ctl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    event_kind;
  logic [1:0]              token_kind;
  logic [TEXT_W-1:0]       token_byte;
  logic [TOKEN_LINE_W-1:0] token_line;
  logic [TOKEN_COL_W-1:0]  start_column;
  logic [TOKEN_COL_W-1:0]  end_column;
  logic                    last_of_run;

  modport source (
    output valid, output event_kind, output token_kind, output token_byte,
    output token_line, output start_column, output end_column,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input event_kind, input token_kind, input token_byte,
    input token_line, input start_column, input end_column,
    input last_of_run, output ready
  );
endinterface

>>> src/config_text_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_lexer
// Splits a byte stream into name, number, delimiter and string tokens.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one text byte per item; byte 0 ends the text and closes any
//            open token.
//   out_ch : content items for each byte of an open token, and a completion
//            item with kind, start line and column span when a token ends.
//            last_of_run marks the final item caused by one input byte.
//   Path: an input byte's results are registered in the input register,
//   then in the result queue, before they are offered on out_ch.
//   Throughput: one byte per cycle while the queue has room. A byte that
//   closes a name or number and is itself a delimiter or the start of a new
//   token gives two items; the output drains one item per cycle while
//   out_ch.ready is high, so a run of such bytes is limited by the single
//   read port of the four-entry result queue.
//   Stall: when out_ch.ready is low the queue fills and in_ch.ready drops
//   once fewer than two slots are free; no item is lost.
//   Reset: synchronous, active low; lexer idle, line and column at 1,
//   queue empty.
// ----------------------------------------------------------------------------
module config_text_lexer #(
  parameter int LINE_BITS   = ctl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = ctl_pkg::COLUMN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ctl_in_if.sink     in_ch,
  ctl_out_if.source  out_ch
);
  import ctl_pkg::*;

  push_t push;
  logic  room;

  // Lexer with input register
  ctl_lex_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  // Result queue
  ctl_res_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

>>> src/ctl_lex_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_lex_core
// Input register, lexer state and per-byte classification. Produces up to
// two results per byte and pushes them into the result queue.
// ----------------------------------------------------------------------------
module ctl_lex_core #(
  parameter int LINE_BITS   = ctl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = ctl_pkg::COLUMN_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ctl_in_if.sink         in_ch,
  input  logic           room,
  output ctl_pkg::push_t push
);
  import ctl_pkg::*;

  // Input register
  logic              in_valid_r;
  logic [TEXT_W-1:0] byte_r;
  logic              fire;

  // Lexer state
  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [LINE_BITS-1:0]   osl_r, osl_nxt;
  logic [COLUMN_BITS-1:0] osc_r, osc_nxt;

  // Classification
  logic is_nul, is_nl, is_ws, is_q, is_dl, is_dig, is_numb;
  logic [LINE_BITS-1:0]   line_inc, adv_line;
  logic [COLUMN_BITS-1:0] col_inc, adv_col;

  // Outcome of treating the byte as the first one after a token
  logic                   idle_has;
  result_t                idle_res;
  mode_t                  idle_mode;
  logic [LINE_BITS-1:0]   idle_line, idle_osl;
  logic [COLUMN_BITS-1:0] idle_col, idle_osc;

  logic    n0, n1;
  result_t r0, r1;

  function automatic result_t mk_res(
    input logic                   ev,
    input logic [1:0]             kind,
    input logic [TEXT_W-1:0]      tbyte,
    input logic [LINE_BITS-1:0]   line,
    input logic [COLUMN_BITS-1:0] sc,
    input logic [COLUMN_BITS-1:0] ec
  );
    result_t r;
    r.event_kind   = ev;
    r.token_kind   = kind;
    r.token_byte   = tbyte;
    r.token_line   = TOKEN_LINE_W'(line);
    r.start_column = TOKEN_COL_W'(sc);
    r.end_column   = TOKEN_COL_W'(ec);
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign fire        = in_valid_r && room;
  assign in_ch.ready = !in_valid_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.text_byte;
    end
  end

  // Byte classes and saturating counter steps
  always_comb begin
    is_nul  = (byte_r == CH_NUL);
    is_nl   = (byte_r == CH_NL);
    is_ws   = (byte_r <= CH_SPACE);
    is_q    = (byte_r == CH_QUOTE);
    is_dl   = (byte_r == CH_LBRACE) || (byte_r == CH_RBRACE) ||
              (byte_r == CH_LPAREN) || (byte_r == CH_RPAREN) ||
              (byte_r == CH_EQUALS) || (byte_r == CH_COMMA)  ||
              (byte_r == CH_SEMI)   || (byte_r == CH_COLON);
    is_dig  = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
    is_numb = is_dig || (byte_r == CH_DOT);

    line_inc = (line_r == '1) ? line_r : line_r + LINE_BITS'(1);
    col_inc  = (col_r == '1) ? col_r : col_r + COLUMN_BITS'(1);
    adv_line = is_nl ? line_inc : line_r;
    adv_col  = is_nl ? COLUMN_BITS'(1) : col_inc;
  end

  // Byte seen between tokens
  always_comb begin
    idle_has  = 1'b0;
    idle_res  = '0;
    idle_mode = MODE_IDLE;
    idle_osl  = osl_r;
    idle_osc  = osc_r;
    idle_line = adv_line;
    idle_col  = adv_col;
    if (is_nul) begin
      // end of text: counters back to the start
      idle_line = LINE_BITS'(1);
      idle_col  = COLUMN_BITS'(1);
    end else if (is_ws) begin
      idle_has = 1'b0;
    end else if (is_q) begin
      idle_mode = MODE_STRING;
      idle_osl  = line_r;
      idle_osc  = col_inc;
    end else if (is_dl) begin
      idle_has = 1'b1;
      idle_res = mk_res(EV_DONE, KIND_DELIM, byte_r, line_r, col_r, col_r);
    end else begin
      idle_mode = is_dig ? MODE_NUMBER : MODE_NAME;
      idle_osl  = line_r;
      idle_osc  = col_r;
      idle_has  = 1'b1;
      idle_res  = mk_res(EV_CONTENT, is_dig ? KIND_NUMBER : KIND_NAME, byte_r,
                         line_r, col_r, '0);
    end
  end

  // Per-mode handling
  always_comb begin
    mode_nxt = mode_r;
    line_nxt = adv_line;
    col_nxt  = adv_col;
    osl_nxt  = osl_r;
    osc_nxt  = osc_r;
    n0       = 1'b0;
    n1       = 1'b0;
    r0       = '0;
    r1       = '0;
    case (mode_r)
      MODE_STRING: begin
        n0 = 1'b1;
        if (is_nul || is_q) begin
          r0       = mk_res(EV_DONE, KIND_STRING, CH_NUL, osl_r, osc_r, col_r);
          mode_nxt = MODE_IDLE;
          if (is_nul) begin
            line_nxt = LINE_BITS'(1);
            col_nxt  = COLUMN_BITS'(1);
          end
        end else begin
          r0 = mk_res(EV_CONTENT, KIND_STRING, byte_r, osl_r, osc_r, '0);
        end
      end
      MODE_NAME, MODE_NUMBER: begin
        n0 = 1'b1;
        if ((mode_r == MODE_NAME) ? (!is_ws && !is_q && !is_dl) : is_numb) begin
          r0 = mk_res(EV_CONTENT, (mode_r == MODE_NAME) ? KIND_NAME : KIND_NUMBER,
                      byte_r, osl_r, osc_r, '0);
        end else begin
          // close the token, then treat the byte as fresh
          r0 = mk_res(EV_DONE, (mode_r == MODE_NAME) ? KIND_NAME : KIND_NUMBER,
                      CH_NUL, osl_r, osc_r, col_r);
          n1       = idle_has;
          r1       = idle_res;
          mode_nxt = idle_mode;
          line_nxt = idle_line;
          col_nxt  = idle_col;
          osl_nxt  = idle_osl;
          osc_nxt  = idle_osc;
        end
      end
      default: begin
        n0       = idle_has;
        r0       = idle_res;
        mode_nxt = idle_mode;
        line_nxt = idle_line;
        col_nxt  = idle_col;
        osl_nxt  = idle_osl;
        osc_nxt  = idle_osc;
      end
    endcase
    // mark the final result of this byte
    if (n1) begin
      r1.last_of_run = 1'b1;
    end else begin
      r0.last_of_run = 1'b1;
    end
  end

  assign push.v0 = fire && n0;
  assign push.v1 = fire && n1;
  assign push.r0 = r0;
  assign push.r1 = r1;

  // State update on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      line_r <= LINE_BITS'(1);
      col_r  <= COLUMN_BITS'(1);
      osl_r  <= '0;
      osc_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      osl_r  <= osl_nxt;
      osc_r  <= osc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a second result only follows a token completion
  assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0 && (push.r0.event_kind == EV_DONE))
    else $error("second result without a completed token");

  // counters never fall to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != '0) && (col_r != '0))
    else $error("line or column counter at zero");

  // inside a string every byte gives exactly one result
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (mode_r == MODE_STRING)) |-> push.v0 && !push.v1)
    else $error("string byte gave wrong number of results");
`endif

endmodule

>>> src/ctl_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_res_fifo
// Small result queue: up to two items in per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module ctl_res_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  ctl_pkg::push_t push,
  output logic           room,
  ctl_out_if.source      out_ch
);
  import ctl_pkg::*;

  localparam int PTR_W = $clog2(RES_DEPTH);

  result_t          mem_r [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             pop;
  result_t          head;

  assign room = (count_r <= (PTR_W+1)'(RES_DEPTH - 2));
  assign pop  = out_ch.valid && out_ch.ready;

  // Pointer and fill arithmetic
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.v0) + PTR_W'(push.v1);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + (PTR_W+1)'(push.v0) + (PTR_W+1)'(push.v1)
                 - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push.r1;
    end
  end

  // Head of queue to the output channel
  assign head                = mem_r[rd_ptr_r];
  assign out_ch.valid        = (count_r != '0);
  assign out_ch.event_kind   = head.event_kind;
  assign out_ch.token_kind   = head.token_kind;
  assign out_ch.token_byte   = head.token_byte;
  assign out_ch.token_line   = head.token_line;
  assign out_ch.start_column = head.start_column;
  assign out_ch.end_column   = head.end_column;
  assign out_ch.last_of_run  = head.last_of_run;

`ifndef NO_ASSERTIONS
  // fill never exceeds depth
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(RES_DEPTH))
    else $error("result queue overflow");

  // pushes only when two slots were free
  assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> room)
    else $error("push into result queue without room");

  // in a pair only the second item closes the run
  assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.r1.last_of_run && !push.r0.last_of_run)
    else $error("run marker misplaced in result pair");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text lexer. A table of directed bytes, then
// random config-like text. Every accepted byte goes through a local lexer
// model and each output item is checked against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import ctl_pkg::*;

  localparam int RANDOM_ITEMS = 1374;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [TOKEN_COL_W-1:0]  COL_MAX  = '1;
  localparam logic [TOKEN_LINE_W-1:0] LINE_MAX = '1;
  localparam result_t NO_RES = '0;

  localparam logic [7:0] SINGLES [8] = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
                                         CH_EQUALS, CH_COMMA, CH_SEMI, CH_COLON};

  // One directed byte; typed rows carry their expected items
  typedef struct packed {
    logic [7:0] text;
    logic       typed;
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // delimiter straight after reset, line 1 column 1
    '{CH_LBRACE, 1'b1, 2'd1,
      '{EV_DONE, KIND_DELIM, CH_LBRACE, 16'd1, 12'd1, 12'd1, 1'b1}, NO_RES},
    // name opens at column 2
    '{8'h61, 1'b1, 2'd1,
      '{EV_CONTENT, KIND_NAME, 8'h61, 16'd1, 12'd2, 12'd0, 1'b1}, NO_RES},
    '{8'hFF, 1'b0, 2'd0, NO_RES, NO_RES},
    // delimiter closes the name and is a token itself
    '{CH_RBRACE, 1'b1, 2'd2,
      '{EV_DONE, KIND_NAME, CH_NUL, 16'd1, 12'd2, 12'd4, 1'b0},
      '{EV_DONE, KIND_DELIM, CH_RBRACE, 16'd1, 12'd4, 12'd4, 1'b1}},
    '{CH_SPACE,  1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_ZERO,   1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_DOT,    1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_NINE,   1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_NL,     1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h01,     1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_NL,     1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h80,     1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h35,     1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_LPAREN, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_RPAREN, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_EQUALS, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_COMMA,  1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_SEMI,   1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_COLON,  1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h7E,     1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_NUL,    1'b0, 2'd0, NO_RES, NO_RES},
    // end of text while idle gives nothing
    '{CH_NUL,    1'b1, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_NUL,    1'b0, 2'd0, NO_RES, NO_RES}
  };

  logic clk;
  logic rst_n;

  ctl_in_if  in_ch ();
  ctl_out_if out_ch ();

  config_text_lexer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Lexer model state
  mode_t                   scan_mode = MODE_IDLE;
  logic [TOKEN_LINE_W-1:0] cur_line  = 16'd1;
  logic [TOKEN_COL_W-1:0]  cur_col   = 12'd1;
  logic [TOKEN_LINE_W-1:0] tok_line  = '0;
  logic [TOKEN_COL_W-1:0]  tok_col   = '0;

  result_t     pending_results [$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned error_count  = 0;
  int unsigned burst_left   = 0;

  // Typed expectation travelling with the byte on offer
  logic       row_typed = 1'b0;
  logic [1:0] row_n     = 2'd0;
  result_t    row_r0    = '0;
  result_t    row_r1    = '0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic is_single(input logic [7:0] c);
    foreach (SINGLES[i]) if (c == SINGLES[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic result_t make_result(input logic ev, input logic [1:0] kind,
                                          input logic [7:0] b,
                                          input logic [TOKEN_LINE_W-1:0] line,
                                          input logic [TOKEN_COL_W-1:0] sc,
                                          input logic [TOKEN_COL_W-1:0] ec);
    result_t r;
    r.event_kind   = ev;
    r.token_kind   = kind;
    r.token_byte   = b;
    r.token_line   = line;
    r.start_column = sc;
    r.end_column   = ec;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Cursor update: newline moves down in every mode, counters saturate
  function automatic void move_cursor(input logic [7:0] c);
    if (c == CH_NL) begin
      if (cur_line != LINE_MAX) cur_line = cur_line + 1'b1;
      cur_col = 12'd1;
    end else if (cur_col != COL_MAX) begin
      cur_col = cur_col + 1'b1;
    end
  endfunction

  function automatic void rewind_text();
    scan_mode = MODE_IDLE;
    cur_line  = 16'd1;
    cur_col   = 12'd1;
  endfunction

  // Byte seen between tokens; returns the number of items it gives (0 or 1)
  function automatic int start_token(input logic [7:0] c, output result_t r);
    logic digit;
    r     = '0;
    digit = (c >= CH_ZERO && c <= CH_NINE);
    if (c == CH_NUL) begin
      rewind_text();
      return 0;
    end
    if (c <= CH_SPACE) begin
      move_cursor(c);
      return 0;
    end
    if (c == CH_QUOTE) begin
      scan_mode = MODE_STRING;
      tok_line  = cur_line;
      tok_col   = (cur_col == COL_MAX) ? COL_MAX : cur_col + 1'b1;
      move_cursor(c);
      return 0;
    end
    if (is_single(c)) begin
      r = make_result(EV_DONE, KIND_DELIM, c, cur_line, cur_col, cur_col);
      move_cursor(c);
      return 1;
    end
    scan_mode = digit ? MODE_NUMBER : MODE_NAME;
    tok_line  = cur_line;
    tok_col   = cur_col;
    r = make_result(EV_CONTENT, digit ? KIND_NUMBER : KIND_NAME, c, tok_line, tok_col, '0);
    move_cursor(c);
    return 1;
  endfunction

  // Predicted items for one accepted byte
  function automatic int lex_byte(input logic [7:0] c, output result_t r0,
                                  output result_t r1);
    logic [1:0] kind;
    logic       stays;
    int         n;
    r0   = '0;
    r1   = '0;
    n    = 0;
    kind = (scan_mode == MODE_NUMBER) ? KIND_NUMBER : KIND_NAME;
    case (scan_mode)
      MODE_STRING: begin
        n = 1;
        if (c == CH_NUL || c == CH_QUOTE) begin
          r0 = make_result(EV_DONE, KIND_STRING, CH_NUL, tok_line, tok_col, cur_col);
          scan_mode = MODE_IDLE;
          if (c == CH_NUL) rewind_text();
          else move_cursor(c);
        end else begin
          r0 = make_result(EV_CONTENT, KIND_STRING, c, tok_line, tok_col, '0);
          move_cursor(c);
        end
      end
      MODE_NAME, MODE_NUMBER: begin
        if (scan_mode == MODE_NAME) stays = c > CH_SPACE && c != CH_QUOTE && !is_single(c);
        else stays = (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT;
        if (stays) begin
          r0 = make_result(EV_CONTENT, kind, c, tok_line, tok_col, '0);
          n  = 1;
          move_cursor(c);
        end else begin
          // token closes, then the byte is taken afresh
          r0 = make_result(EV_DONE, kind, CH_NUL, tok_line, tok_col, cur_col);
          scan_mode = MODE_IDLE;
          n = 1 + start_token(c, r1);
        end
      end
      default: n = start_token(c, r0);
    endcase
    if (n == 1) r0.last_of_run = 1'b1;
    else if (n == 2) r1.last_of_run = 1'b1;
    return n;
  endfunction

  function automatic logic [7:0] pick_name_byte(input logic first);
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 1) == 0) c = 8'h61 + 8'($urandom_range(0, 25));
      else c = 8'($urandom_range(33, 255));
    end while (c == CH_QUOTE || is_single(c) || (first && c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  // Offer one byte in bursts with random gaps; returns once accepted
  task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input logic [1:0] n = 2'd0, input result_t r0 = '0,
                           input result_t r1 = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    row_typed       <= typed;
    row_n           <= n;
    row_r0          <= r0;
    row_r1          <= r1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      error_count++;
    end
  endtask

  // Prediction on input acceptance, comparison on output acceptance
  result_t pred0, pred1, want;
  int      pred_n;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pred_n = lex_byte(in_ch.text_byte, pred0, pred1);
        if (row_typed) begin
          if (row_n > 0) pending_results.push_back(row_r0);
          if (row_n > 1) pending_results.push_back(row_r1);
        end else begin
          if (pred_n > 0) pending_results.push_back(pred0);
          if (pred_n > 1) pending_results.push_back(pred1);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("event_kind",   16'(want.event_kind),   16'(out_ch.event_kind));
          check_field("token_kind",   16'(want.token_kind),   16'(out_ch.token_kind));
          check_field("token_byte",   16'(want.token_byte),   16'(out_ch.token_byte));
          check_field("token_line",   16'(want.token_line),   16'(out_ch.token_line));
          check_field("start_column", 16'(want.start_column), 16'(out_ch.start_column));
          check_field("end_column",   16'(want.end_column),   16'(out_ch.end_column));
          check_field("last_of_run",  16'(want.last_of_run),  16'(out_ch.last_of_run));
        end
      end
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off
  initial begin : receiver
    int unsigned rx_mode, rx_left, rx_phase, hold_left;
    logic        hold_done;
    rx_mode      = 0;
    rx_left      = 0;
    rx_phase     = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= (rx_phase % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned pick, len;
    logic [7:0]  c;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      push_byte(DIRECTED[i].text, DIRECTED[i].typed, DIRECTED[i].n,
                DIRECTED[i].r0, DIRECTED[i].r1);

    // Config-like text, with some noise and unclosed strings
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) push_byte(pick_name_byte(i == 0));
      end else if (pick < 35) begin
        push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        len = $urandom_range(0, 6);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) push_byte(CH_DOT);
          else push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end else if (pick < 45) begin
        push_byte(CH_QUOTE);
        len = $urandom_range(0, 10);
        repeat (len) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
          if ($urandom_range(0, 9) == 0) c = CH_NL;
          push_byte(c);
        end
        if ($urandom_range(0, 9) != 0) push_byte(CH_QUOTE);
      end else if (pick < 65) begin
        push_byte(SINGLES[$urandom_range(0, 7)]);
      end else if (pick < 80) begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          if ($urandom_range(0, 4) < 3) push_byte(CH_SPACE);
          else push_byte(8'($urandom_range(1, 32)));
        end
      end else if (pick < 87) begin
        push_byte(CH_NL);
      end else if (pick < 91) begin
        push_byte(CH_NUL);
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #400_000;
    $display("tb: failure");
    $finish;
  end

endmodule
